// ===== src/cvfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cvfa_pkg;

  // Store geometry and frame layout
  localparam int MAX_CELLS       = 25;
  localparam int VOLTAGE_FRAMES  = 7;
  localparam int CELLS_PER_FRAME = 4;
  localparam int STRIDE_LOG2     = 16;   // frame identifier step of 0x10000
  localparam int MV_LIMIT        = 7000;
  localparam logic [28:0] BASE_RESET = 29'd417343732;

  localparam int ID_W  = 29;
  localparam int MV_W  = 13;
  localparam int CNT_W = 5;              // count and 1-based index fields
  localparam int SUM_W = $clog2(MAX_CELLS * MV_LIMIT + 1);
  localparam int POS_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int K_W   = $clog2(VOLTAGE_FRAMES + 1);
  localparam int CMP_W = $clog2(VOLTAGE_FRAMES * CELLS_PER_FRAME + MAX_CELLS + 1);
  localparam int SLOT_W = (CELLS_PER_FRAME > 1) ? $clog2(CELLS_PER_FRAME) : 1;

  typedef logic [MV_W-1:0] mv_t;

  // Running aggregate handed from the scan unit to the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    mv_t              maxv;
    logic [CNT_W-1:0] maxi;
    mv_t              minv;
    logic [CNT_W-1:0] mini;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/cvfa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One voltage slot of the shift ring.
module cvfa_cell
  import cvfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire mv_t  din,
  output mv_t       dout
);

  mv_t value;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= din;
    end
  end

  assign dout = value;

endmodule

`default_nettype wire

// ===== src/cvfa_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accumulates count, sum, first max and first min over the leading
// nonzero cells as they stream past the ring head.
module cvfa_scan
  import cvfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             clear,
  input  wire logic             step,
  input  wire mv_t              v,
  input  wire logic [CNT_W-1:0] idx,
  output scan_res_t             res
);

  scan_res_t acc;
  logic      leading;

  always_ff @(posedge clk) begin
    if (clear) begin
      acc     <= '0;
      leading <= 1'b1;
    end else if (step && leading) begin
      if (v == '0) begin
        leading <= 1'b0;
      end else begin
        acc.count <= acc.count + 1'b1;
        acc.sum   <= acc.sum + SUM_W'(v);
        if (acc.count == '0) begin
          acc.maxv <= v;
          acc.maxi <= idx;
          acc.minv <= v;
          acc.mini <= idx;
        end else begin
          if (v > acc.maxv) begin
            acc.maxv <= v;
            acc.maxi <= idx;
          end
          if (v < acc.minv) begin
            acc.minv <= v;
            acc.mini <= idx;
          end
        end
      end
    end
  end

  assign res = acc;

endmodule

`default_nettype wire

// ===== src/cvfa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cvfa_div
  import cvfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== src/cell_voltage_frame_aggregator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: a matching frame transfer rotates the cell ring once, then starts the serial
//   divider, lets it run, and loads the result into the output register.
// A new frame is taken only after the result has moved into the output register;
//   frames that do not match are taken every cycle in idle and give no result.
// The cell ring rotation and the serial divider bound how often matching frames are taken.
// Reset: synchronous, active high; clears all cell slots, loads the default base id.
module cell_voltage_frame_aggregator
  import cvfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [ID_W-1:0]    cfg_data,
  // frame input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ID_W-1:0]    frame_id,
  input  wire logic [3:0]         frame_length,
  input  wire logic [63:0]        frame_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    cells_valid,
  output logic [CNT_W-1:0]        cell_count,
  output logic [MV_W-1:0]         max_mv,
  output logic [CNT_W-1:0]        max_cell,
  output logic [MV_W-1:0]         min_mv,
  output logic [CNT_W-1:0]        min_cell,
  output logic [MV_W-1:0]         avg_mv,
  output logic [MV_W-1:0]         delta_mv
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a frame
  localparam logic [2:0] S_SCAN   = 3'd1;  // rotating the ring once
  localparam logic [2:0] S_DSTART = 3'd2;  // aggregate settled, kick divider
  localparam logic [2:0] S_DIV    = 3'd3;  // divider running
  localparam logic [2:0] S_DONE   = 3'd4;  // result waiting for output room

  logic [2:0] state;
  logic [2:0] state_next;

  // ---------------------------------------------------------------------------
  // Configuration: the base id register takes a transfer whenever out of reset.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] base_id;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_id <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame match: id = base + k * 0x10000 with k below VOLTAGE_FRAMES.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] id_diff;
  logic            id_match;
  logic            in_xfer;

  assign id_diff  = frame_id - base_id;
  assign id_match = (frame_id >= base_id)
                 && (id_diff[STRIDE_LOG2-1:0] == '0)
                 && (id_diff[ID_W-1:STRIDE_LOG2] < (ID_W-STRIDE_LOG2)'(VOLTAGE_FRAMES));

  // held off during reset so no transfer is taken and dropped
  assign in_stall = rst || (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Slot decode: little-endian 16-bit word, both bytes inside the length,
  // and a value from 1 to MV_LIMIT; anything else clears the slot.
  mv_t slot_dec [CELLS_PER_FRAME];

  always_comb begin
    for (int i = 0; i < CELLS_PER_FRAME; i++) begin
      logic [15:0] raw;
      raw = frame_data[16*i +: 16];
      if ((frame_length > 4'(2*i + 1)) && (raw != '0) && (raw <= 16'(MV_LIMIT))) begin
        slot_dec[i] = raw[MV_W-1:0];
      end else begin
        slot_dec[i] = '0;
      end
    end
  end

  // Frame captured at the transfer
  mv_t             slots [CELLS_PER_FRAME];
  logic [CMP_W-1:0] kbase;   // first cell index the frame rewrites

  always_ff @(posedge clk) begin
    if (in_xfer && id_match) begin
      slots <= slot_dec;
      kbase <= CMP_W'(id_diff[STRIDE_LOG2 +: K_W]) * CMP_W'(CELLS_PER_FRAME);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell ring: during the scan every cell takes its upper neighbor, and the
  // head value re-enters at the tail, replaced by the frame's slot when the
  // head position lies in the frame's range. After one full rotation the ring
  // is back in place with the store updated.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos;       // cell index currently at the ring head
  logic             shift;
  logic             last;
  mv_t              ring [MAX_CELLS];
  mv_t              tail_in;
  logic [CMP_W-1:0] off;
  logic             hit;

  assign shift = (state == S_SCAN);
  assign last  = (pos == POS_W'(MAX_CELLS - 1));
  assign off   = CMP_W'(pos) - kbase;
  assign hit   = (CMP_W'(pos) >= kbase) && (off < CMP_W'(CELLS_PER_FRAME));
  assign tail_in = hit ? slots[off[SLOT_W-1:0]] : ring[0];

  for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
    mv_t din;
    if (g == MAX_CELLS - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_body
      assign din = ring[g+1];
    end
    cvfa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (din),
      .dout  (ring[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_xfer) begin
      pos <= '0;
    end else if (shift) begin
      pos <= last ? '0 : pos + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Aggregate over the updated values as they leave the tail input.
  // ---------------------------------------------------------------------------
  scan_res_t agg;

  cvfa_scan u_scan (
    .clk   (clk),
    .clear (in_xfer && id_match),
    .step  (shift),
    .v     (tail_in),
    .idx   (CNT_W'(pos) + 1'b1),
    .res   (agg)
  );

  // Average: sum / count on the serial divider
  logic             div_done;
  logic [SUM_W-1:0] quotient;

  cvfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (agg.sum),
    .divisor  (agg.count),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register. A new frame is taken as soon as the result
  // moves into the output register, even while that register is stalled.
  // ---------------------------------------------------------------------------
  logic ready_res;
  logic load;

  assign ready_res = (state == S_DONE) || ((state == S_DIV) && div_done);
  assign load      = ready_res && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer && id_match) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = load ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cells_valid <= (agg.count != '0);
      cell_count  <= agg.count;
      max_mv      <= agg.maxv;
      max_cell    <= agg.maxi;
      min_mv      <= agg.minv;
      min_cell    <= agg.mini;
      avg_mv      <= (agg.count != '0) ? quotient[MV_W-1:0] : '0;
      delta_mv    <= agg.maxv - agg.minv;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cvfa_pkg::*;

  localparam int SETTLE_CYCLES = 60;     // settle time after the last pending result
  localparam int ITEMS_PER_PHASE = 320;  // matching frames in a full random phase
  localparam logic [ID_W-1:0] ID_MAX = '1;

  // One result transfer, in port order
  typedef struct packed {
    logic             cells_valid;
    logic [CNT_W-1:0] cell_count;
    logic [MV_W-1:0]  max_mv;
    logic [CNT_W-1:0] max_cell;
    logic [MV_W-1:0]  min_mv;
    logic [CNT_W-1:0] min_cell;
    logic [MV_W-1:0]  avg_mv;
    logic [MV_W-1:0]  delta_mv;
  } cell_stats_t;

  // Tracks the cell store and the pack statistics each matching frame must produce.
  class cell_stats_tracker;
    bit [ID_W-1:0] base;
    bit [MV_W-1:0] cells[MAX_CELLS];
    cell_stats_t   stats_due[$];
    int            errors;

    function new();
      base = BASE_RESET;
      foreach (cells[i]) cells[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return stats_due.size();
    endfunction

    // Little-endian slot; out of length, zero or above the limit reads as empty
    function bit [MV_W-1:0] decode_slot(bit [63:0] data, bit [3:0] len, int slot);
      int unsigned off;
      bit [15:0]   v;
      off = 2 * slot;
      if (len < 2 || off + 1 >= len) return '0;
      v = data[off*8 +: 16];
      if (v == 0 || v > MV_LIMIT) return '0;
      return v[MV_W-1:0];
    endfunction

    function void note_frame(bit [ID_W-1:0] id, bit [3:0] len, bit [63:0] data);
      bit [ID_W-1:0] diff;
      int            k;
      int            cell_idx;
      int            count;
      int unsigned   sum;
      cell_stats_t   s;
      if (id < base) return;
      diff = id - base;
      if (diff[STRIDE_LOG2-1:0] != 0) return;
      k = int'(diff >> STRIDE_LOG2);
      if (k >= VOLTAGE_FRAMES) return;
      for (int i = 0; i < CELLS_PER_FRAME; i++) begin
        cell_idx = k * CELLS_PER_FRAME + i;
        if (cell_idx < MAX_CELLS) cells[cell_idx] = decode_slot(data, len, i);
      end
      count = 0;
      while (count < MAX_CELLS && cells[count] != 0) count++;
      s = '0;
      sum = 0;
      if (count > 0) begin
        s.max_mv = cells[0];
        s.min_mv = cells[0];
        s.max_cell = CNT_W'(1);
        s.min_cell = CNT_W'(1);
        for (int i = 0; i < count; i++) begin
          sum += cells[i];
          // strict compares keep the first extreme
          if (cells[i] < s.min_mv) begin
            s.min_mv = cells[i];
            s.min_cell = CNT_W'(i + 1);
          end
          if (cells[i] > s.max_mv) begin
            s.max_mv = cells[i];
            s.max_cell = CNT_W'(i + 1);
          end
        end
        s.avg_mv = MV_W'(sum / count);
      end
      s.cells_valid = (count > 0);
      s.cell_count = CNT_W'(count);
      s.delta_mv = s.max_mv - s.min_mv;
      stats_due.push_back(s);
    endfunction

    function void flag(string what, cell_stats_t want, cell_stats_t got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected %p, got %p", $realtime, what, want, got);
    endfunction

    function void check_stats(cell_stats_t got);
      cell_stats_t want;
      if (stats_due.size() == 0) begin
        flag("result with none pending", '0, got);
        return;
      end
      want = stats_due.pop_front();
      if (got.cells_valid !== want.cells_valid || got.cell_count !== want.cell_count ||
          got.max_mv !== want.max_mv || got.max_cell !== want.max_cell ||
          got.min_mv !== want.min_mv || got.min_cell !== want.min_cell ||
          got.avg_mv !== want.avg_mv || got.delta_mv !== want.delta_mv)
        flag("stats mismatch", want, got);
    endfunction
  endclass

  // Clock, reset and block inputs; everything starts at a known value
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ID_W-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ID_W-1:0]   frame_id = '0;
  logic [3:0]        frame_length = '0;
  logic [63:0]       frame_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              cells_valid;
  logic [CNT_W-1:0]  cell_count;
  logic [MV_W-1:0]   max_mv;
  logic [CNT_W-1:0]  max_cell;
  logic [MV_W-1:0]   min_mv;
  logic [CNT_W-1:0]  min_cell;
  logic [MV_W-1:0]   avg_mv;
  logic [MV_W-1:0]   delta_mv;

  cell_stats_tracker tracker = new();
  bit                calm = 1'b0;    // when set, neither side idles
  int                stall_left = 0;
  cell_stats_t       seen_stats;

  cell_voltage_frame_aggregator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .frame_data   (frame_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cells_valid  (cells_valid),
    .cell_count   (cell_count),
    .max_mv       (max_mv),
    .max_cell     (max_cell),
    .min_mv       (min_mv),
    .min_cell     (min_cell),
    .avg_mv       (avg_mv),
    .delta_mv     (delta_mv)
  );

  always #5 clk = ~clk;

  // Per-item idle draw shared by both sides
  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Mostly plausible cell voltages, with empties, limits and out-of-range codes mixed in
  function automatic bit [15:0] pick_mv();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'($urandom_range(MV_LIMIT + 1, 16'hFFFF));
      2: return 16'd1;
      3: return 16'(MV_LIMIT);
      4: return 16'($urandom_range(1, MV_LIMIT));
      default: return 16'($urandom_range(2800, 4200));
    endcase
  endfunction

  // Result side: check every transfer, then hold stall for a fresh random count.
  // Outputs are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_stats = {cells_valid, cell_count, max_mv, max_cell,
                      min_mv, min_cell, avg_mv, delta_mv};
        tracker.check_stats(seen_stats);
        stall_left = draw_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Called at a rising edge. Valid only drops when a gap follows, so it is never
  // lowered and raised in the same step; the transfer is noted at its accepting edge.
  task automatic send_frame(bit [ID_W-1:0] id, bit [3:0] len, bit [63:0] data);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_id <= id;
    frame_length <= len;
    frame_data <= data;
    do @(posedge clk); while (in_stall);
    tracker.note_frame(id, len, data);
  endtask

  // Voltage frame k of the current base with four explicit slot codes
  task automatic send_cells(int k, bit [3:0] len, bit [15:0] v0, bit [15:0] v1,
                            bit [15:0] v2, bit [15:0] v3);
    send_frame(tracker.base + ID_W'(k << STRIDE_LOG2), len, {v3, v2, v1, v0});
  endtask

  // Drop valid, let every pending result arrive, then give the block time to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called with the block idle
  task automatic write_base(bit [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.base = value;
  endtask

  // Random phase: mostly voltage frames that fit under the 29-bit ceiling,
  // the rest near-miss and random identifiers
  task automatic run_random_phase(int n_match);
    int            matched;
    int            kmax;
    bit [31:0]     room;
    bit [ID_W-1:0] id;
    bit [3:0]      len;
    bit [63:0]     data;
    matched = 0;
    room = 32'(ID_MAX) - 32'(tracker.base);
    kmax = ((room >> STRIDE_LOG2) < VOLTAGE_FRAMES) ? int'(room >> STRIDE_LOG2)
                                                    : VOLTAGE_FRAMES - 1;
    while (matched < n_match) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      len = ($urandom_range(0, 4) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
      data = {pick_mv(), pick_mv(), pick_mv(), pick_mv()};
      if ($urandom_range(0, 3) != 0) begin
        id = tracker.base + ID_W'($urandom_range(0, kmax) << STRIDE_LOG2);
        matched++;
      end else begin
        data = {$urandom, $urandom};
        case ($urandom_range(0, 4))
          0: id = tracker.base - 1'b1;
          1: id = tracker.base + ID_W'(($urandom_range(0, kmax) << STRIDE_LOG2)
                                      + $urandom_range(1, 16'hFFFF));
          2: id = tracker.base + ID_W'($urandom_range(VOLTAGE_FRAMES, 64) << STRIDE_LOG2);
          3: id = ID_MAX;
          default: id = ID_W'($urandom);
        endcase
      end
      send_frame(id, len, data);
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset base: fill all 25 cells, with limits and ties
    send_cells(0, 4'd8, 16'd1, 16'(MV_LIMIT), 16'd3300, 16'd3300);
    send_cells(1, 4'd8, 16'd3300, 16'd1, 16'(MV_LIMIT), 16'd3999);
    send_cells(2, 4'd15, 16'd3500, 16'd3600, 16'd3700, 16'd3800);  // length above eight
    send_cells(3, 4'd9, 16'd4000, 16'd4100, 16'd4200, 16'd2500);
    send_cells(4, 4'd8, 16'd3200, 16'd3210, 16'd3220, 16'd3230);
    send_cells(5, 4'd8, 16'd3300, 16'd3310, 16'd3320, 16'd3330);
    // last frame: only its first slot lands inside the store
    send_cells(6, 4'd8, 16'd4100, 16'd5000, 16'd6000, 16'd6500);
    send_cells(3, 4'd3, 16'd4000, 16'd4100, 16'd4200, 16'd4300);  // second slot cut by length
    send_cells(3, 4'd1, 16'd4000, 16'd4100, 16'd4200, 16'd4300);  // short frame
    send_cells(3, 4'd0, 16'd4000, 16'd4100, 16'd4200, 16'd4300);
    send_cells(1, 4'd8, 16'd3300, 16'(MV_LIMIT + 1), 16'hFFFF, 16'd3999);
    // identifiers that must be ignored
    send_frame(tracker.base - 1'b1, 4'd8, 64'h0DAC_0DAC_0DAC_0DAC);
    send_frame('0, 4'd8, 64'h0DAC_0DAC_0DAC_0DAC);
    send_frame(tracker.base + 1'b1, 4'd8, 64'h0DAC_0DAC_0DAC_0DAC);
    send_frame(tracker.base + ID_W'(VOLTAGE_FRAMES << STRIDE_LOG2), 4'd8, '1);
    send_frame(ID_MAX, 4'd15, '1);
    // emptied first cell gives an all-zero result
    send_cells(0, 4'd8, 16'd0, 16'd0, 16'd0, 16'd0);
    send_cells(0, 4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cells(0, 4'd2, 16'd3700, 16'd3800, 16'd3900, 16'd4000);
    drain_results();

    // Extreme bases
    write_base('0);
    send_cells(0, 4'd8, 16'd3000, 16'd3100, 16'd3200, 16'd3300);
    send_cells(6, 4'd8, 16'd3000, 16'd3100, 16'd3200, 16'd3300);
    drain_results();
    write_base(ID_MAX);
    send_frame(ID_MAX - 1'b1, 4'd8, 64'h0FA0_0FA0_0FA0_0FA0);
    send_frame(ID_MAX, 4'd8, 64'h0FA0_0FA0_0FA0_0FA0);
    drain_results();

    // Random part across several base settings
    run_random_phase(ITEMS_PER_PHASE / 4);
    write_base('0);
    run_random_phase(ITEMS_PER_PHASE);
    write_base(ID_W'($urandom));
    run_random_phase(ITEMS_PER_PHASE);
    write_base(ID_MAX - ID_W'($urandom_range(3 << STRIDE_LOG2, 5 << STRIDE_LOG2)));
    run_random_phase(ITEMS_PER_PHASE);
    write_base(BASE_RESET);
    calm = 1'b0;
    run_random_phase(ITEMS_PER_PHASE);
    write_base(ID_W'($urandom));
    run_random_phase(ITEMS_PER_PHASE / 2);

    if (tracker.pending() != 0)
      $display("%0d results never arrived", tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
